### sv/fffl_pkg.sv
// package: widths, codes, payload and control types for the free-list allocator
`default_nettype none
package fffl_pkg;

    localparam int ADDR_BITS        = 48;
    localparam int SIZE_BITS        = 32;
    localparam int ALU_BITS         = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;
    localparam int MARGIN_BITS      = 8;
    localparam int FREE_ENTRIES_DEF = 16;

    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd24;

    localparam logic ACT_FREE  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREE_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SPLIT_CHK,
        S_SPLIT_WR,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [ALU_BITS-1:0] a;
        logic [ALU_BITS-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_BITS-1:0] res;
        logic                carry;
    } t_alu_rsp;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] block_address;
        logic [SIZE_BITS-1:0] request_size;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] granted_address;
    } t_rsp;

endpackage
`default_nettype wire

### sv/fffl_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module fffl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### sv/fffl_alu.sv
// shared add / subtract unit with carry out
`default_nettype none
module fffl_alu (
    input  var fffl_pkg::t_alu_req i_req,
    output fffl_pkg::t_alu_rsp     o_rsp
);
    import fffl_pkg::*;

    logic [ALU_BITS-1:0] w_b;
    logic [ALU_BITS:0]   w_sum;

    always_comb begin
        w_b   = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
        w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {{ALU_BITS{1'b0}}, (i_req.op == ALU_SUB)};
        o_rsp.res   = w_sum[ALU_BITS-1:0];
        o_rsp.carry = w_sum[ALU_BITS];
    end

endmodule
`default_nettype wire

### sv/first_fit_free_list_allocator.sv
// top level: first-fit free-block table with sequencer, shared alu and table ram
//
//  channel | signals                     | transaction when
//  --------+-----------------------------+----------------------------
//  request | i_valid, o_stall, i_data    | i_valid && !o_stall
//  result  | o_valid, i_stall, o_data    | o_valid && !i_stall
//  config  | i_cfg_we, i_cfg_wdata       | i_cfg_we
//
// free: decode, table write, result (no write if ignored or full). allocate: decode,
// scan read+compare per entry, on a fit a split check, then split write or close.
// the table is a circular buffer; a free moves the head pointer back one.
// reset empties the table at once; entries are never read before written.
// a result waits in the output register while i_stall is high; o_stall stays
// high from accept until the result is loaded.
`default_nettype none
module first_fit_free_list_allocator #(
    parameter int FREE_ENTRIES = fffl_pkg::FREE_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  var fffl_pkg::t_req                    i_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output fffl_pkg::t_rsp                        o_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [fffl_pkg::MARGIN_BITS-1:0] i_cfg_wdata
);
    import fffl_pkg::*;

    localparam int PTR_W = $clog2(FREE_ENTRIES);
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int ENT_W = ADDR_BITS + SIZE_BITS;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FREE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FREE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    t_state                 r_state, n_state;
    t_req                   r_in, n_in;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    logic [PTR_W-1:0]       r_wptr, n_wptr;
    logic [SIZE_BITS-1:0]   r_diff, n_diff;
    logic [ADDR_BITS-1:0]   r_start, n_start;
    t_status                r_status, n_status;
    logic [ADDR_BITS-1:0]   r_grant, n_grant;
    t_rsp                   r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic [MARGIN_BITS-1:0] r_margin, n_margin;

    t_alu_req               w_alu_req;
    t_alu_rsp               w_alu_rsp;
    logic                   w_we;
    logic [PTR_W-1:0]       w_waddr;
    logic [ENT_W-1:0]       w_wdata;
    logic                   w_re;
    logic [PTR_W-1:0]       w_raddr;
    logic [ENT_W-1:0]       w_rdata;
    logic [ADDR_BITS-1:0]   w_rd_start;
    logic [SIZE_BITS-1:0]   w_rd_bytes;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    assign w_rd_start = w_rdata[ENT_W-1:SIZE_BITS];
    assign w_rd_bytes = w_rdata[SIZE_BITS-1:0];

    fffl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FREE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fffl_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_margin    <= MARGIN_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_margin    <= n_margin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_wptr   <= n_wptr;
        r_diff   <= n_diff;
        r_start  <= n_start;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_diff      = r_diff;
        n_start     = r_start;
        n_status    = r_status;
        n_grant     = r_grant;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_margin    = i_cfg_we ? i_cfg_wdata : r_margin;

        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = ALU_BITS'(w_rd_bytes);
        w_alu_req.b  = ALU_BITS'(r_in.request_size);
        w_we         = 1'b0;
        w_waddr      = r_ptr;
        w_wdata      = w_rdata;
        w_re         = 1'b0;
        w_raddr      = r_ptr;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_grant = '0;
                if (r_in.action == ACT_FREE) begin
                    if (r_in.block_address == '0 || r_in.request_size == '0) begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end else if (r_count == CNT_FULL) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_head  = ptr_dec(r_head);
                        n_state = S_FREE_WR;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = ST_NOFIT;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_ptr   = r_head;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FREE_WR: begin
                w_we     = 1'b1;
                w_waddr  = r_head;
                w_wdata  = {r_in.block_address, r_in.request_size};
                n_count  = r_count + CNT_ONE;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_SCAN_RD: begin
                w_re    = 1'b1;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // bytes - request, carry set when the entry fits
                if (w_alu_rsp.carry) begin
                    n_diff  = w_alu_rsp.res[SIZE_BITS-1:0];
                    n_start = w_rd_start;
                    n_grant = w_rd_start;
                    n_state = S_SPLIT_CHK;
                end else if (r_idx == r_count - CNT_ONE) begin
                    n_status = ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + CNT_ONE;
                    n_ptr   = ptr_inc(r_ptr);
                    n_state = S_SCAN_RD;
                end
            end
            S_SPLIT_CHK: begin
                // margin - diff borrows when the leftover exceeds the margin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = ALU_BITS'(r_margin);
                w_alu_req.b  = ALU_BITS'(r_diff);
                n_status     = ST_OK;
                if (!w_alu_rsp.carry) begin
                    n_state = S_SPLIT_WR;
                end else if (r_idx == r_count - CNT_ONE) begin
                    n_count = r_count - CNT_ONE;
                    n_state = S_DONE;
                end else begin
                    n_wptr  = r_ptr;
                    n_state = S_CLOSE_RD;
                end
            end
            S_SPLIT_WR: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = ALU_BITS'(r_start);
                w_alu_req.b  = ALU_BITS'(r_in.request_size);
                w_we         = 1'b1;
                w_waddr      = r_ptr;
                w_wdata      = {w_alu_rsp.res[ADDR_BITS-1:0], r_diff};
                n_state      = S_DONE;
            end
            S_CLOSE_RD: begin
                w_re    = 1'b1;
                w_raddr = ptr_inc(r_ptr);
                n_ptr   = ptr_inc(r_ptr);
                n_state = S_CLOSE_WR;
            end
            S_CLOSE_WR: begin
                w_we    = 1'b1;
                w_waddr = r_wptr;
                w_wdata = w_rdata;
                n_wptr  = r_ptr;
                n_idx   = r_idx + CNT_ONE;
                if (r_idx + CNT_ONE == r_count - CNT_ONE) begin
                    n_count = r_count - CNT_ONE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLOSE_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.status          = r_status;
                    n_out.granted_address = r_grant;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire
